/* hw/rtl/tcw_pkg.sv */
// Shared types, constants and address helpers for the text console writer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MOVE_COUNT = COLUMNS * (ROWS - 1);
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] ATTR_RESET   = 8'd9;

  localparam logic [1:0] FUNC_PUT_CURSOR = 2'd0;
  localparam logic [1:0] FUNC_PUT_AT     = 2'd1;
  localparam logic [1:0] FUNC_READ       = 2'd2;
  localparam logic [1:0] FUNC_CLEAR      = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
  } out_item_t;

  // One cycle's access to the cell store: one write port, one read port.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  function automatic logic pos_in_range(input logic [6:0] col, input logic [4:0] row);
    return (8'(col) < 8'(COLUMNS)) && (6'(row) < 6'(ROWS));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [6:0] col,
                                                  input logic [4:0] row);
    return ADDR_W'(int'(row) * COLUMNS + int'(col));
  endfunction

endpackage

/* hw/rtl/tcw_cell_ram.sv */
// Screen cell store: one write port and one registered read port.
// Depends on tcw_pkg for the depth, address width and request struct.
`timescale 1ns / 1ps

module tcw_cell_ram (
  input  logic              clk,
  input  tcw_pkg::ram_req_t req,
  output logic [15:0]       rd_data
);

  logic [15:0] mem [tcw_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

/* hw/rtl/tcw_ctrl.sv */
// Sequencer of the console: cursor, item decode and the scroll/clear sweep.
// Depends on tcw_pkg; drives the request port of tcw_cell_ram.
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcw_pkg::in_item_t   in_data,
  input  logic [7:0]          attr,
  output logic                res_valid,
  input  logic                res_ready,
  output tcw_pkg::out_item_t  res,
  output tcw_pkg::ram_req_t   ram_req,
  input  logic [15:0]         ram_rd_data
);

  typedef enum logic [2:0] {
    ST_SWEEP = 3'b001,
    ST_IDLE  = 3'b010,
    ST_DONE  = 3'b100
  } state_t;

  localparam logic [tcw_pkg::CNT_W-1:0] COLS_C = tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::CNT_W-1:0] MOVE_C = tcw_pkg::CNT_W'(tcw_pkg::MOVE_COUNT);
  localparam logic [tcw_pkg::CNT_W-1:0] LAST_C = tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT);
  localparam logic [6:0] COL_LAST = 7'(tcw_pkg::COLUMNS - 1);
  localparam logic [4:0] ROW_LAST = 5'(tcw_pkg::ROWS - 1);

  state_t                      state_r, state_nxt;
  logic [tcw_pkg::CNT_W-1:0]   sw_r, sw_nxt;
  logic                        clear_all_r, clear_all_nxt;
  logic                        boot_r, boot_nxt;
  logic                        hit_r, hit_nxt;
  logic [6:0]                  cur_col_r, cur_col_nxt;
  logic [4:0]                  cur_row_r, cur_row_nxt;

  logic                        accept;
  logic                        in_range;
  logic                        is_newline;
  logic                        wraps;
  logic [tcw_pkg::CNT_W-1:0]   sw_m1;
  logic [tcw_pkg::CNT_W-1:0]   sw_src;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign in_range   = tcw_pkg::pos_in_range(in_data.col, in_data.row);
  assign is_newline = (in_data.char_code == tcw_pkg::NEWLINE_CODE);
  // The cursor leaves the last row: either a newline there or a put on its last cell.
  assign wraps      = (cur_row_r == ROW_LAST) && (is_newline || (cur_col_r == COL_LAST));
  assign sw_m1      = sw_r - 1'b1;
  assign sw_src     = sw_r + COLS_C;

  assign res_valid      = (state_r == ST_DONE);
  assign res.cell_char  = hit_r ? ram_rd_data[7:0]  : 8'd0;
  assign res.cell_attr  = hit_r ? ram_rd_data[15:8] : 8'd0;
  assign res.cursor_col = cur_col_r;
  assign res.cursor_row = cur_row_r;

  always_comb begin
    state_nxt     = state_r;
    sw_nxt        = sw_r;
    clear_all_nxt = clear_all_r;
    boot_nxt      = boot_r;
    hit_nxt       = hit_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    ram_req       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          hit_nxt   = (in_data.func == tcw_pkg::FUNC_READ) && in_range;
          state_nxt = ST_DONE;
          sw_nxt    = '0;
          case (in_data.func)
            tcw_pkg::FUNC_PUT_CURSOR: begin
              if (!is_newline) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = tcw_pkg::cell_addr(cur_col_r, cur_row_r);
                ram_req.wdata = {attr, in_data.char_code};
              end
              if (wraps) begin
                cur_col_nxt   = '0;
                cur_row_nxt   = ROW_LAST;
                clear_all_nxt = 1'b0;
                state_nxt     = ST_SWEEP;
              end else if (is_newline || (cur_col_r == COL_LAST)) begin
                cur_col_nxt = '0;
                cur_row_nxt = cur_row_r + 5'd1;
              end else begin
                cur_col_nxt = cur_col_r + 7'd1;
              end
            end
            tcw_pkg::FUNC_PUT_AT: begin
              ram_req.we    = in_range;
              ram_req.waddr = tcw_pkg::cell_addr(in_data.col, in_data.row);
              ram_req.wdata = {attr, in_data.char_code};
            end
            tcw_pkg::FUNC_READ: begin
              ram_req.re    = in_range;
              ram_req.raddr = tcw_pkg::cell_addr(in_data.col, in_data.row);
            end
            tcw_pkg::FUNC_CLEAR: begin
              cur_col_nxt   = '0;
              cur_row_nxt   = '0;
              clear_all_nxt = 1'b1;
              state_nxt     = ST_SWEEP;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        // Reads run one count ahead of writes: the cell read at count k, address
        // k + COLUMNS, is written in the next cycle to address k, i.e. one row up.
        ram_req.re    = !clear_all_r && (sw_r < MOVE_C);
        ram_req.raddr = tcw_pkg::ADDR_W'(sw_src);
        ram_req.we    = (sw_r != '0);
        ram_req.waddr = tcw_pkg::ADDR_W'(sw_m1);
        ram_req.wdata = (!clear_all_r && (sw_r <= MOVE_C)) ? ram_rd_data : 16'd0;
        sw_nxt        = sw_r + 1'b1;
        if (sw_r == LAST_C) begin
          hit_nxt   = 1'b0;
          boot_nxt  = 1'b0;
          state_nxt = boot_r ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sw_r        <= '0;
      clear_all_r <= 1'b1;
      boot_r      <= 1'b1;
      hit_r       <= 1'b0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      sw_r        <= sw_nxt;
      clear_all_r <= clear_all_nxt;
      boot_r      <= boot_nxt;
      hit_r       <= hit_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
    end
  end

endmodule

/* hw/rtl/text_console_writer_with_scroll.sv */
// Top level of the text console writer: attribute register, result register
// and the instances of tcw_ctrl and tcw_cell_ram. Depends on tcw_pkg.
//
//   port group | direction | payload             | handshake
//   in_*       | in        | tcw_pkg::in_item_t  | in_valid / in_stall
//   out_*      | out       | tcw_pkg::out_item_t | out_valid / out_stall
//   cfg_*      | in        | 8-bit attribute     | cfg_we, no wait
//
// An ordinary beat is decoded with its store access in ST_IDLE, then handed off in ST_DONE.
// A scroll or a clear adds a sweep over every cell of the store,
// one cell a cycle through the single write port of the cell store.
// After reset the same sweep clears the store; in_stall stays high for it.
// The result register lets a new beat be taken while out_stall holds the last.
`timescale 1ns / 1ps

module text_console_writer_with_scroll (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  logic [7:0]         text_attr_r;
  logic               out_valid_r;
  tcw_pkg::out_item_t out_data_r;
  logic               res_valid;
  logic               res_ready;
  tcw_pkg::out_item_t res;
  tcw_pkg::ram_req_t  ram_req;
  logic [15:0]        ram_rd_data;

  assign res_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= tcw_pkg::ATTR_RESET;
    end else if (cfg_we) begin
      text_attr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  tcw_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .attr        (text_attr_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  tcw_cell_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

endmodule

/* hw/rtl/tcw_checker.sv */
// Port-level checks for the text console writer, bound to its top level.
// Depends on tcw_pkg for the screen size.
`timescale 1ns / 1ps

module tcw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input tcw_pkg::out_item_t out_data
);

  // The block works on one beat at a time, so it is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // Reset starts the clearing sweep and empties the result register.
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not busy or result pending after reset");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (8'(out_data.cursor_col) < 8'(tcw_pkg::COLUMNS))
               && (6'(out_data.cursor_row) < 6'(tcw_pkg::ROWS)))
    else $error("cursor outside the screen");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind text_console_writer_with_scroll tcw_checker u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
